// ===== hw/rtl/acftp_pkg.sv =====
`default_nettype none

package acftp_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 8;

	// inverse square of the radius allowance of one hundredth
	localparam int ALLOW_INV_SQ = 10000;
	localparam int ALLOW_W = 14;

	// split point of the root for the output multipliers
	localparam int PROD_SPLIT = 32;

	typedef enum logic [1:0] {
		ST_FOUND        = 2'd0,
		ST_COINCIDENT   = 2'd1,
		ST_SHORT_RADIUS = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acftp_div_cell.sv =====
`default_nettype none

// one restoring division step: one quotient bit per cell
module acftp_div_cell #(
	parameter int NB = 126,
	parameter int LW = 65,
	parameter int SW = 8
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            v_in,
	input  wire [LW:0]     rem_in,
	input  wire [NB-1:0]   nq_in,
	input  wire [LW-1:0]   dvs_in,
	input  wire [SW-1:0]   side_in,
	output logic           v_q,
	output logic [LW:0]    rem_q,
	output logic [NB-1:0]  nq_q,
	output logic [LW-1:0]  dvs_q,
	output logic [SW-1:0]  side_q
);

	logic [LW:0] trial;
	logic        ge;

	assign trial = {rem_in[LW-1:0], nq_in[NB-1]};
	assign ge    = trial >= {1'b0, dvs_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? (trial - {1'b0, dvs_in}) : trial;
		// dividend bits leave at the top, quotient bits enter at the bottom
		nq_q   <= {nq_in[NB-2:0], ge};
		dvs_q  <= dvs_in;
		side_q <= side_in;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acftp_sqrt_cell.sv =====
`default_nettype none

// one digit-by-digit square root step: one root bit per cell
module acftp_sqrt_cell #(
	parameter int NB = 126,
	parameter int SB = 63,
	parameter int SW = 8
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            v_in,
	input  wire [SB+2:0]   rem_in,
	input  wire [SB-1:0]   root_in,
	input  wire [NB-1:0]   rad_in,
	input  wire [SW-1:0]   side_in,
	output logic           v_q,
	output logic [SB+2:0]  rem_q,
	output logic [SB-1:0]  root_q,
	output logic [NB-1:0]  rad_q,
	output logic [SW-1:0]  side_q
);

	logic [SB+2:0] trial;
	logic [SB+2:0] cand;
	logic          ge;

	assign trial = {rem_in[SB:0], rad_in[NB-1:NB-2]};
	assign cand  = {1'b0, root_in, 2'b01};
	assign ge    = trial >= cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= ge ? (trial - cand) : trial;
		root_q <= {root_in[SB-2:0], ge};
		rad_q  <= {rad_in[NB-3:0], 2'b00};
		side_q <= side_in;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/acftp_center.sv =====
`default_nettype none

// offset along the perpendicular, round to nearest, saturate; zero center on an error status
module acftp_center
	import acftp_pkg::*;
#(
	parameter int W  = 32,
	parameter int SB = 63,
	parameter int QH = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  v_in,
	input  wire [SB-1:0]         d_in,
	input  wire signed [W:0]     msx_in,
	input  wire signed [W:0]     msy_in,
	input  wire [W-1:0]          ux_in,
	input  wire [W-1:0]          uy_in,
	input  wire                  pxn_in,
	input  wire                  pyn_in,
	input  wire [1:0]            st_in,
	output logic                 done,
	output logic signed [W-1:0]  center_x,
	output logic signed [W-1:0]  center_y,
	output logic [1:0]           status
);

	localparam int DL  = PROD_SPLIT;
	localparam int DH  = SB - DL;
	localparam int TW  = W + SB;
	localparam int SWD = W + SB + 4;
	localparam logic signed [SWD-1:0] MAXP = (SWD'(1) <<< (W - 1)) - SWD'(1);
	localparam logic signed [SWD-1:0] MINN = -(SWD'(1) <<< (W - 1));

	function automatic logic [W-1:0] finish(input logic signed [W:0] ms,
		input logic [TW-1:0] t, input logic neg);
		logic signed [SWD-1:0] m;
		logic signed [SWD-1:0] tt;
		logic signed [SWD-1:0] s;
		logic signed [SWD-1:0] sh;
		m  = SWD'(ms) <<< QH;
		tt = $signed(SWD'(t)) <<< 1;
		if (neg) begin
			tt = -tt;
		end
		s  = m + tt + (SWD'(1) <<< QH);
		sh = s >>> (QH + 1);
		if (sh > MAXP) begin
			return MAXP[W-1:0];
		end else if (sh < MINN) begin
			return MINN[W-1:0];
		end
		return sh[W-1:0];
	endfunction

	logic              v_s1, v_s2;
	logic [W+DL-1:0]   plx_s1, ply_s1;
	logic [W+DH-1:0]   phx_s1, phy_s1;
	logic [TW-1:0]     tx_s2, ty_s2;
	logic signed [W:0] msx_s1, msy_s1, msx_s2, msy_s2;
	logic              pxn_s1, pyn_s1, pxn_s2, pyn_s2;
	logic [1:0]        st_s1, st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		plx_s1 <= (W + DL)'(uy_in) * (W + DL)'(d_in[DL-1:0]);
		phx_s1 <= (W + DH)'(uy_in) * (W + DH)'(d_in[SB-1:DL]);
		ply_s1 <= (W + DL)'(ux_in) * (W + DL)'(d_in[DL-1:0]);
		phy_s1 <= (W + DH)'(ux_in) * (W + DH)'(d_in[SB-1:DL]);
		msx_s1 <= msx_in;
		msy_s1 <= msy_in;
		pxn_s1 <= pxn_in;
		pyn_s1 <= pyn_in;
		st_s1  <= st_in;

		tx_s2  <= {phx_s1, {DL{1'b0}}} + TW'(plx_s1);
		ty_s2  <= {phy_s1, {DL{1'b0}}} + TW'(ply_s1);
		msx_s2 <= msx_s1;
		msy_s2 <= msy_s1;
		pxn_s2 <= pxn_s1;
		pyn_s2 <= pyn_s1;
		st_s2  <= st_s1;

		status <= st_s2;
		if (st_s2 == ST_FOUND) begin
			center_x <= finish(msx_s2, tx_s2, pxn_s2);
			center_y <= finish(msy_s2, ty_s2, pyn_s2);
		end else begin
			center_x <= '0;
			center_y <= '0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/arc_center_from_two_points.sv =====
// pipeline from start to done, the same for every COORD_WIDTH:
//   input, squares, length, 126 division cells, allowance check, 63 root cells, 3 output stages
// throughput: one transaction per cycle; busy is always low, every cell passes on each cycle
// done is high for one cycle with the result; the receiver cannot stall
// reset clears only the valid bits of the pipeline; transactions in flight are dropped
`default_nettype none

module arc_center_from_two_points
	import acftp_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire signed [COORD_WIDTH-1:0] start_x,
	input  wire signed [COORD_WIDTH-1:0] start_y,
	input  wire signed [COORD_WIDTH-1:0] end_x,
	input  wire signed [COORD_WIDTH-1:0] end_y,
	input  wire [COORD_WIDTH-2:0]        radius,
	input  wire                          clockwise,
	input  wire                          minor_arc,
	output logic                         done,
	output logic signed [COORD_WIDTH-1:0] center_x,
	output logic signed [COORD_WIDTH-1:0] center_y,
	output logic [1:0]                   status
);

	localparam int W    = COORD_WIDTH;
	localparam int QK   = 128 - 2 * W;
	localparam int QH   = QK / 2;
	localparam int RW   = 2 * W - 2;
	localparam int NB   = RW + QK;
	localparam int SB   = NB / 2;
	localparam int LW   = 2 * W + 1;
	localparam int CMPW = NB + ALLOW_W;
	localparam int DSW  = 2 * (W + 1) + 2 * W + 3 + RW;
	localparam int QSW  = 2 * (W + 1) + 2 * W + 2 + 2;
	localparam int LAT  = 3 + NB + 2 + SB + 3;

	assign busy = 1'b0;

	// stage 1: differences, midpoint sums, perpendicular signs
	logic signed [W:0] dx_c, dy_c, msx_c, msy_c;
	logic              flip_c;

	assign dx_c   = (W + 1)'(end_x) - (W + 1)'(start_x);
	assign dy_c   = (W + 1)'(end_y) - (W + 1)'(start_y);
	assign msx_c  = (W + 1)'(start_x) + (W + 1)'(end_x);
	assign msy_c  = (W + 1)'(start_y) + (W + 1)'(end_y);
	assign flip_c = clockwise ^ minor_arc;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [W-1:0]      ux_s1, uy_s1, ux_s2, uy_s2, ux_s3, uy_s3;
	logic [W-2:0]      r_s1;
	logic signed [W:0] msx_s1, msy_s1, msx_s2, msy_s2, msx_s3, msy_s3;
	logic              pxn_s1, pyn_s1, pxn_s2, pyn_s2, pxn_s3, pyn_s3;
	logic              coinc_s1, coinc_s2, coinc_s3;
	logic [2*W-1:0]    ux2_s2, uy2_s2;
	logic [RW-1:0]     r2_s2, r2_s3;
	logic [LW-1:0]     l2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ux_s1    <= dx_c[W] ? W'(-dx_c) : W'(dx_c);
		uy_s1    <= dy_c[W] ? W'(-dy_c) : W'(dy_c);
		r_s1     <= radius;
		msx_s1   <= msx_c;
		msy_s1   <= msy_c;
		pxn_s1   <= flip_c ? dy_c[W] : (!dy_c[W] && dy_c != '0);
		pyn_s1   <= flip_c ? (!dx_c[W] && dx_c != '0) : dx_c[W];
		coinc_s1 <= (dx_c == '0) && (dy_c == '0);

		ux2_s2   <= (2 * W)'(ux_s1) * (2 * W)'(ux_s1);
		uy2_s2   <= (2 * W)'(uy_s1) * (2 * W)'(uy_s1);
		r2_s2    <= RW'(r_s1) * RW'(r_s1);
		ux_s2    <= ux_s1;
		uy_s2    <= uy_s1;
		msx_s2   <= msx_s1;
		msy_s2   <= msy_s1;
		pxn_s2   <= pxn_s1;
		pyn_s2   <= pyn_s1;
		coinc_s2 <= coinc_s1;

		l2_s3    <= LW'(ux2_s2) + LW'(uy2_s2);
		r2_s3    <= r2_s2;
		ux_s3    <= ux_s2;
		uy_s3    <= uy_s2;
		msx_s3   <= msx_s2;
		msy_s3   <= msy_s2;
		pxn_s3   <= pxn_s2;
		pyn_s3   <= pyn_s2;
		coinc_s3 <= coinc_s2;
	end

	// division chain: q = r^2 * 2^QK / |p|^2
	logic          dv   [0:NB];
	logic [LW:0]   drem [0:NB];
	logic [NB-1:0] dnq  [0:NB];
	logic [LW-1:0] ddvs [0:NB];
	logic [DSW-1:0] dside [0:NB];

	assign dv[0]    = v_s3;
	assign drem[0]  = '0;
	assign dnq[0]   = {r2_s3, {QK{1'b0}}};
	assign ddvs[0]  = l2_s3;
	assign dside[0] = {msx_s3, msy_s3, ux_s3, uy_s3, pxn_s3, pyn_s3, coinc_s3, r2_s3};

	for (genvar i = 0; i < NB; i++) begin : g_div
		acftp_div_cell #(
			.NB(NB),
			.LW(LW),
			.SW(DSW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (dv[i]),
			.rem_in (drem[i]),
			.nq_in  (dnq[i]),
			.dvs_in (ddvs[i]),
			.side_in(dside[i]),
			.v_q    (dv[i+1]),
			.rem_q  (drem[i+1]),
			.nq_q   (dnq[i+1]),
			.dvs_q  (ddvs[i+1]),
			.side_q (dside[i+1])
		);
	end

	logic signed [W:0] msx_d, msy_d;
	logic [W-1:0]      ux_d, uy_d;
	logic              pxn_d, pyn_d, coinc_d;
	logic [RW-1:0]     r2_d;
	logic [NB-1:0]     q_d;

	assign {msx_d, msy_d, ux_d, uy_d, pxn_d, pyn_d, coinc_d, r2_d} = dside[NB];
	assign q_d = dnq[NB];

	// stages 4 and 5: subtract the quarter, or test the deficit against the allowance
	logic [QK-2:0]          deficit_c;
	logic [QK-2+ALLOW_W:0]  dm_s4;
	logic                   lt_s4;
	logic [NB-1:0]          d2_s4, d2_s5;
	logic [RW-1:0]          r2_s4;
	logic                   coinc_s4;
	logic [2*(W+1)+2*W+1:0] pass_s4;
	logic [QSW-1:0]         qside_s5;
	logic                   allowed_c;
	status_t                st_c;

	assign deficit_c = {1'b1, {(QK-2){1'b0}}} - {1'b0, q_d[QK-3:0]};
	assign allowed_c = CMPW'(dm_s4) < (CMPW'(r2_s4) << (QK - 2 * FRAC_BITS));

	always_comb begin
		if (coinc_s4) begin
			st_c = ST_COINCIDENT;
		end else if (lt_s4 && !allowed_c) begin
			st_c = ST_SHORT_RADIUS;
		end else begin
			st_c = ST_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= dv[NB];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		lt_s4    <= q_d[NB-1:QK-2] == '0;
		dm_s4    <= (QK - 1 + ALLOW_W)'(deficit_c) * (QK - 1 + ALLOW_W)'(ALLOW_INV_SQ);
		d2_s4    <= q_d - (NB'(1) << (QK - 2));
		r2_s4    <= r2_d;
		coinc_s4 <= coinc_d;
		pass_s4  <= {msx_d, msy_d, ux_d, uy_d, pxn_d, pyn_d};

		d2_s5    <= lt_s4 ? '0 : d2_s4;
		qside_s5 <= {pass_s4, st_c};
	end

	// square root chain
	logic          sv    [0:SB];
	logic [SB+2:0] srem  [0:SB];
	logic [SB-1:0] sroot [0:SB];
	logic [NB-1:0] srad  [0:SB];
	logic [QSW-1:0] sside [0:SB];

	assign sv[0]    = v_s5;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign srad[0]  = d2_s5;
	assign sside[0] = qside_s5;

	for (genvar j = 0; j < SB; j++) begin : g_sqrt
		acftp_sqrt_cell #(
			.NB(NB),
			.SB(SB),
			.SW(QSW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (sv[j]),
			.rem_in (srem[j]),
			.root_in(sroot[j]),
			.rad_in (srad[j]),
			.side_in(sside[j]),
			.v_q    (sv[j+1]),
			.rem_q  (srem[j+1]),
			.root_q (sroot[j+1]),
			.rad_q  (srad[j+1]),
			.side_q (sside[j+1])
		);
	end

	logic signed [W:0] msx_r, msy_r;
	logic [W-1:0]      ux_r, uy_r;
	logic              pxn_r, pyn_r;
	logic [1:0]        st_r;

	assign {msx_r, msy_r, ux_r, uy_r, pxn_r, pyn_r, st_r} = sside[SB];

	acftp_center #(
		.W (W),
		.SB(SB),
		.QH(QH)
	) u_center (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (sv[SB]),
		.d_in    (sroot[SB]),
		.msx_in  (msx_r),
		.msy_in  (msy_r),
		.ux_in   (ux_r),
		.uy_in   (uy_r),
		.pxn_in  (pxn_r),
		.pyn_in  (pyn_r),
		.st_in   (st_r),
		.done    (done),
		.center_x(center_x),
		.center_y(center_y),
		.status  (status)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("transaction did not complete after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a matching transaction");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_FOUND |-> center_x == '0 && center_y == '0)
		else $error("nonzero center on an error status");

	a_coincident: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_COINCIDENT |->
			$past(start_x == end_x && start_y == end_y, LAT))
		else $error("coincident status for distinct points");

	a_short_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SHORT_RADIUS |->
			$past(start_x != end_x || start_y != end_y, LAT))
		else $error("short radius status for coincident points");

endmodule

`default_nettype wire

// ===== tb/arc_center_from_two_points_tb.sv =====
module arc_center_from_two_points_tb;
	import acftp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 250;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		status_t            st;
	} arc_center_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] start_x, start_y, end_x, end_y;
	logic [30:0]        radius;
	logic               clockwise, minor_arc;
	logic               done;
	logic signed [31:0] center_x, center_y;
	logic [1:0]         status;

	arc_center_t pending_centers[$];
	int          errors;
	int          idle_cycles;
	bit          idling_on;

	arc_center_from_two_points dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.radius    (radius),
		.clockwise (clockwise),
		.minor_arc (minor_arc),
		.done      (done),
		.center_x  (center_x),
		.center_y  (center_y),
		.status    (status)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] root_floor(logic [191:0] v);
		logic [63:0] res;
		logic [63:0] cand;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = res | (64'd1 << b);
			if ({128'd0, cand} * {128'd0, cand} <= v)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] center_coord(logic signed [32:0] msum,
			logic [32:0] pmag, bit pneg, logic [63:0] d);
		logic [191:0]        pu;
		logic signed [191:0] t;
		logic signed [191:0] s;
		pu = {159'd0, pmag} * {128'd0, d};
		t = pneg ? -$signed(pu) : $signed(pu);
		s = ($signed({{159{msum[32]}}, msum}) <<< 32) + (t <<< 1) + (192'sd1 <<< 32);
		s = s >>> 33;
		if (s > 192'sd2147483647)
			return 32'sh7fffffff;
		if (s < -192'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	function automatic arc_center_t predict_center(logic signed [31:0] sx,
			logic signed [31:0] sy, logic signed [31:0] ex, logic signed [31:0] ey,
			logic [30:0] r, logic cw, logic mi);
		arc_center_t         res;
		logic signed [32:0]  dx, dy;
		logic [32:0]         ux, uy;
		logic [191:0]        l2, r2, q, quarter, d2;
		logic [63:0]         d;
		bit                  flip, pxneg, pyneg;
		res.cx = '0;
		res.cy = '0;
		dx = $signed({ex[31], ex}) - $signed({sx[31], sx});
		dy = $signed({ey[31], ey}) - $signed({sy[31], sy});
		if (dx == 0 && dy == 0) begin
			res.st = ST_COINCIDENT;
			return res;
		end
		ux = dx[32] ? -dx : dx;
		uy = dy[32] ? -dy : dy;
		l2 = {159'd0, ux} * {159'd0, ux} + {159'd0, uy} * {159'd0, uy};
		r2 = {161'd0, r} * {161'd0, r};
		q = (r2 << 64) / l2;
		quarter = 192'd1 << 62;
		if (q < quarter) begin
			// short radius tolerated within one hundredth of r
			if ((quarter - q) * 192'd10000 < (r2 << 48)) begin
				d2 = '0;
			end else begin
				res.st = ST_SHORT_RADIUS;
				return res;
			end
		end else begin
			d2 = q - quarter;
		end
		d = root_floor(d2);
		flip = cw ^ mi;
		pxneg = flip ? (dy < 0) : (dy > 0);
		pyneg = flip ? (dx > 0) : (dx < 0);
		res.cx = center_coord($signed({sx[31], sx}) + $signed({ex[31], ex}), uy, pxneg, d);
		res.cy = center_coord($signed({sy[31], sy}) + $signed({ey[31], ey}), ux, pyneg, d);
		res.st = ST_FOUND;
		return res;
	endfunction

	task automatic report_mismatch(string field, logic signed [31:0] got,
			logic signed [31:0] want);
		$display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $time);
		errors++;
	endtask

	// record expected center for each accepted transaction
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_centers.push_back(predict_center(start_x, start_y, end_x, end_y,
				radius, clockwise, minor_arc));
	end

	always @(posedge clk) begin
		arc_center_t want;
		if (arst_n && done) begin
			if (pending_centers.size() == 0) begin
				report_mismatch("done", 32'sd1, 32'sd0);
			end else begin
				want = pending_centers.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (center_x !== want.cx)
					report_mismatch("center_x", center_x, want.cx);
				if (center_y !== want.cy)
					report_mismatch("center_y", center_y, want.cy);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("arc_center_from_two_points test failed");
			$finish;
		end
	end

	// leaves start high so back-to-back transactions need no extra edge
	task automatic send_segment(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] ex, logic signed [31:0] ey, logic [30:0] r,
			logic cw, logic mi);
		bit was_busy;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		radius <= r;
		clockwise <= cw;
		minor_arc <= mi;
		start <= 1'b1;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
	endtask

	task automatic maybe_idle();
		if (idling_on && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_arc(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] dx, logic signed [31:0] dy, real scale);
		real half, rr;
		half = $sqrt($itor(dx) * $itor(dx) + $itor(dy) * $itor(dy)) / 2.0;
		rr = half * scale;
		if (rr > 2147483647.0)
			rr = 2147483647.0;
		send_segment(sx, sy, sx + dx, sy + dy, 31'($rtoi(rr)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed();
		send_segment(0, 0, 0, 0, 31'd1000, 1'b0, 1'b0);
		send_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, '1,
			1'b1, 1'b1);
		send_segment(0, 0, 32'sd2560, 0, 31'd0, 1'b0, 1'b1);
		// radius exactly half the chord, center is the midpoint
		send_segment(0, 0, 32'sd2560, 0, 31'd1280, 1'b0, 1'b0);
		send_segment(0, 0, 32'sd2560, 0, 31'd1279, 1'b1, 1'b0);
		send_segment(0, 0, 32'sd2560, 0, 31'd1200, 1'b0, 1'b1);
		for (int f = 0; f < 4; f++)
			send_segment(32'sd100, -32'sd300, 32'sd900, 32'sd700, 31'd2000, f[0], f[1]);
		send_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, '1,
			1'b0, 1'b0);
		send_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, '1,
			1'b1, 1'b0);
		send_segment(32'sh7fffff00, 0, 32'sh7fffffff, 0, '1, 1'b0, 1'b1);
		send_segment(32'sh80000000, 0, 32'sh80000001, 0, '1, 1'b1, 1'b1);
		send_segment(0, 0, 1, 0, '1, 1'b0, 1'b0);
		send_segment(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7ffffffe, 31'd1,
			1'b0, 1'b0);
		send_segment(0, 0, 1, 1, 31'd1, 1'b1, 1'b0);
		// huge chord with a radius one hundredth short still passes the allowance
		send_segment(-32'sd1000000, 0, 32'sd1000000, 0, 31'd990000, 1'b0, 1'b0);
		send_segment(-32'sd1000000, 0, 32'sd1000000, 0, 31'd999990, 1'b0, 1'b0);
		start <= 1'b0;
	endtask

	task automatic test_random_fields(int n);
		for (int i = 0; i < n; i++) begin
			send_segment($urandom, $urandom, $urandom, $urandom, 31'($urandom),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			maybe_idle();
		end
		start <= 1'b0;
	endtask

	task automatic test_random_arcs(int n);
		logic signed [31:0] sx, sy, dx, dy;
		real scale;
		for (int i = 0; i < n; i++) begin
			sx = $urandom;
			sy = $urandom;
			dx = $signed($urandom) >>> $urandom_range(0, 30);
			dy = $signed($urandom) >>> $urandom_range(0, 30);
			case ($urandom_range(0, 9))
				0: scale = 0.99 + $urandom_range(0, 1000) / 100000.0;
				1: scale = 1.0;
				2: begin
					dx = 0;
					dy = 0;
					scale = 1.0;
				end
				default: scale = 1.0 + $urandom_range(0, 30000) / 10000.0;
			endcase
			send_arc(sx, sy, dx, dy, scale);
			maybe_idle();
		end
		start <= 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++)
			send_arc($urandom, $urandom, $signed($urandom) >>> 8, $signed($urandom) >>> 8, 1.5);
		start <= 1'b0;
		wait (pending_centers.size() == 0);
		@(posedge clk);
		test_random_arcs(20);
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		idling_on = 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		start_x <= '0;
		start_y <= '0;
		end_x <= '0;
		end_y <= '0;
		radius <= '0;
		clockwise <= 1'b0;
		minor_arc <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_fields(300);
		test_random_arcs(550);
		test_drain_pause();
		idling_on = 1'b0;
		test_random_fields(100);
		test_random_arcs(200);
		wait (pending_centers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("arc_center_from_two_points test passed");
		else
			$display("arc_center_from_two_points test failed");
		$finish;
	end

endmodule
